### rtl/generational_handle_table_top_defines.svh
// Assertion macros used by the handle table top level.
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define GHT_ASSERT_NOW(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Condition holds in the cycle after the trigger.
`define GHT_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

### rtl/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// Types, codes and constants of the generational handle table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ght_pkg;

  localparam int SLOTS_DEFAULT = 64;

  localparam logic [31:0] GEN_RESET    = 32'd1;
  localparam logic [7:0]  FLAG_IN_USE  = 8'h01;
  localparam int          BIT_PUB_READ = 1;
  localparam int          BIT_G_CACHE  = 2;

  typedef enum logic [2:0] {
    MODE_ALLOC        = 3'd0,
    MODE_FREE         = 3'd1,
    MODE_VALIDATE     = 3'd2,
    MODE_TRANSFER     = 3'd3,
    MODE_RESIZE       = 3'd4,
    MODE_UPDATE_FLAGS = 3'd5,
    MODE_GET_META     = 3'd6,
    MODE_RESET_ALL    = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_BAD_SIZE   = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP_RD,
    S_SWEEP_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0] gen;
    logic [7:0]  etype;
    logic [31:0] owner;
    logic [31:0] size;
    logic [31:0] cap;
    logic [7:0]  flags;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic sweep_start;
    logic sweep_read;
    logic sweep_write;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic reset_all;
    logic out_free;
    logic sweep_last;
  } stat_t;

endpackage

### rtl/ght_ctrl.sv
// ----------------------------------------------------------------------------
// ght_ctrl
// Sequencer: accept, execute, and the slot sweep of reset_all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ght_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ght_pkg::stat_t stat,
  output ght_pkg::cmd_t  cmd
);
  import ght_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.reset_all) begin
          cmd.sweep_start = 1'b1;
          state_next      = S_SWEEP_RD;
        end else if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SWEEP_RD: begin
        cmd.sweep_read = 1'b1;
        state_next     = S_SWEEP_WR;
      end
      S_SWEEP_WR: begin
        cmd.sweep_write = 1'b1;
        state_next      = stat.sweep_last ? S_FINISH : S_SWEEP_RD;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/ght_datapath.sv
// ----------------------------------------------------------------------------
// ght_datapath
// Entry memory, in-use bits, live count, request and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ght_datapath #(
  parameter int SLOTS = ght_pkg::SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  ght_pkg::cmd_t       cmd,
  output ght_pkg::stat_t      stat,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic [2:0]          mode,
  input  logic [7:0]          handle_index,
  input  logic [31:0]         handle_generation,
  input  logic [7:0]          type_code,
  input  logic [31:0]         owner_id,
  input  logic [31:0]         obj_size,
  input  logic [7:0]          set_mask,
  input  logic [7:0]          clear_mask,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [1:0]          status,
  output logic [5:0]          result_index,
  output logic [31:0]         result_generation,
  output logic [7:0]          result_type,
  output logic [31:0]         result_owner,
  output logic [7:0]          result_flags,
  output logic [31:0]         result_size,
  output logic [31:0]         result_capacity,
  output logic [6:0]          live_entries
);
  import ght_pkg::*;

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LIVE_W = $clog2(SLOTS + 1);
  localparam logic [8:0]       SLOTS_V = 9'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

  entry_t mem [SLOTS];

  logic [SLOTS-1:0]  in_use;
  logic [SLOTS-1:0]  gen_ok;
  logic [LIVE_W-1:0] live;
  logic [7:0]        pub_mask;
  logic [IDX_W-1:0]  sweep_cnt;

  mode_t             req_mode;
  logic [7:0]        req_idx;
  logic [31:0]       req_gen;
  logic [7:0]        req_type;
  logic [31:0]       req_owner;
  logic [31:0]       req_size;
  logic [7:0]        req_set;
  logic [7:0]        req_clr;
  logic              req_in_range;
  logic              full;
  logic [IDX_W-1:0]  slot;
  entry_t            rd_entry;
  logic              rd_gv;

  logic [IDX_W-1:0]  free_slot;
  logic              free_found;
  logic              in_range;
  logic [IDX_W-1:0]  rd_addr;
  logic [31:0]       cur_gen;
  logic              handle_good;
  entry_t            ent;
  entry_t            sweep_ent;
  logic              wr_exec;
  logic              set_use;
  logic              clr_use;
  logic              live_inc;
  logic              live_dec;
  logic              report;
  status_t           st;
  logic [5:0]        res_idx;
  logic [LIVE_W-1:0] live_after;
  logic [7:0]        pm;
  logic [7:0]        s_bits;
  logic [7:0]        c_bits;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  // Lowest free slot.
  always_comb begin
    free_slot  = '0;
    free_found = 1'b0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!in_use[k]) begin
        free_found = 1'b1;
        free_slot  = IDX_W'(k);
      end
    end
  end

  assign in_range = ({1'b0, handle_index} < SLOTS_V);

  always_comb begin
    if (cmd.sweep_read) begin
      rd_addr = sweep_cnt;
    end else if (mode_t'(mode) == MODE_ALLOC) begin
      rd_addr = free_slot;
    end else if (in_range) begin
      rd_addr = handle_index[IDX_W-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode     <= mode_t'(mode);
      req_idx      <= handle_index;
      req_gen      <= handle_generation;
      req_type     <= type_code;
      req_owner    <= owner_id;
      req_size     <= obj_size;
      req_set      <= set_mask;
      req_clr      <= clear_mask;
      req_in_range <= in_range;
      full         <= !free_found;
      slot         <= rd_addr;
    end
    if (cmd.capture || cmd.sweep_read) begin
      rd_entry <= mem[rd_addr];
      rd_gv    <= gen_ok[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign cur_gen     = rd_gv ? rd_entry.gen : GEN_RESET;
  assign handle_good = req_in_range && in_use[slot] && (cur_gen == req_gen);
  assign pm          = pub_mask & ~FLAG_IN_USE;

  always_comb begin
    ent      = rd_entry;
    ent.gen  = cur_gen;
    wr_exec  = 1'b0;
    set_use  = 1'b0;
    clr_use  = 1'b0;
    live_inc = 1'b0;
    live_dec = 1'b0;
    report   = 1'b0;
    st       = ST_OK;
    res_idx  = req_idx[5:0];
    s_bits   = req_set & pm;
    c_bits   = req_clr & pm;
    if (s_bits[BIT_G_CACHE]) s_bits[BIT_PUB_READ] = 1'b1;
    if (c_bits[BIT_PUB_READ]) c_bits[BIT_G_CACHE] = 1'b1;
    if (req_mode == MODE_ALLOC) begin
      res_idx = '0;
      if (req_size == '0) begin
        st = ST_BAD_SIZE;
      end else if (full) begin
        st = ST_FULL;
      end else begin
        ent.flags = FLAG_IN_USE;
        ent.etype = req_type;
        ent.owner = req_owner;
        ent.size  = req_size;
        ent.cap   = req_size;
        wr_exec   = 1'b1;
        set_use   = 1'b1;
        live_inc  = 1'b1;
        report    = 1'b1;
        res_idx   = 6'(slot);
      end
    end else if (req_mode == MODE_RESIZE && req_size == '0) begin
      st = ST_BAD_SIZE;
    end else if (!handle_good) begin
      st = ST_BAD_HANDLE;
    end else begin
      report = 1'b1;
      unique case (req_mode)
        MODE_FREE: begin
          ent       = '0;
          ent.gen   = cur_gen + 32'd1;
          wr_exec   = 1'b1;
          clr_use   = 1'b1;
          live_dec  = 1'b1;
        end
        MODE_TRANSFER: begin
          ent.owner = req_owner;
          wr_exec   = 1'b1;
        end
        MODE_RESIZE: begin
          ent.size = req_size;
          if (req_size > rd_entry.cap) ent.cap = req_size;
          wr_exec  = 1'b1;
        end
        MODE_UPDATE_FLAGS: begin
          ent.flags = (rd_entry.flags & ~c_bits) | s_bits;
          wr_exec   = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    live_after = live;
    if (live_inc) begin
      live_after = live + LIVE_W'(1);
    end else if (live_dec && live != '0) begin
      live_after = live - LIVE_W'(1);
    end
  end

  // Sweep retires an in-use slot: advance its generation.
  always_comb begin
    sweep_ent       = '0;
    sweep_ent.gen   = cur_gen + 32'd1;
  end

  assign wr_en   = (cmd.commit && wr_exec) || (cmd.sweep_write && in_use[sweep_cnt]);
  assign wr_addr = cmd.sweep_write ? sweep_cnt : slot;
  assign wr_data = cmd.sweep_write ? sweep_ent : ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use    <= '0;
      gen_ok    <= '0;
      live      <= '0;
      pub_mask  <= 8'd254;
      sweep_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) pub_mask <= cfg_wdata;
      if (wr_en) gen_ok[wr_addr] <= 1'b1;
      if (cmd.sweep_start) sweep_cnt <= '0;
      else if (cmd.sweep_write) sweep_cnt <= sweep_cnt + IDX_W'(1);
      if (cmd.commit) begin
        live <= live_after;
        if (set_use) in_use[slot] <= 1'b1;
        if (clr_use) in_use[slot] <= 1'b0;
      end
      if (cmd.finish) begin
        in_use <= '0;
        live   <= '0;
      end
      if (cmd.commit || cmd.finish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status            <= st;
      result_index      <= res_idx;
      result_generation <= report ? ent.gen : '0;
      result_type       <= report ? ent.etype : '0;
      result_owner      <= report ? ent.owner : '0;
      result_flags      <= report ? ent.flags : '0;
      result_size       <= report ? ent.size : '0;
      result_capacity   <= report ? ent.cap : '0;
      live_entries      <= 7'(live_after);
    end else if (cmd.finish) begin
      status            <= ST_OK;
      result_index      <= req_idx[5:0];
      result_generation <= '0;
      result_type       <= '0;
      result_owner      <= '0;
      result_flags      <= '0;
      result_size       <= '0;
      result_capacity   <= '0;
      live_entries      <= '0;
    end
  end

  always_comb begin
    stat.reset_all  = (req_mode == MODE_RESET_ALL);
    stat.out_free   = !out_valid || !out_stall;
    stat.sweep_last = (sweep_cnt == LAST_SLOT);
  end

endmodule

### rtl/generational_handle_table_top.sv
// ----------------------------------------------------------------------------
// generational_handle_table_top
// Generational slot map: alloc, free, validate and edit handle entries.
// ----------------------------------------------------------------------------
// An ordinary request is accepted in S_IDLE: the accept cycle reads the
// entry from the single entry memory (registered read), then S_EXEC checks
// the handle, writes the entry back and loads the result register; S_EXEC
// waits while a previous result is still held off. The result
// register frees the input side, so the next request can be accepted while
// a result waits. Reset_all walks the slots, reading and then writing
// each one (S_SWEEP_RD, S_SWEEP_WR) before its result. Entries carry
// per-slot valid bits, so no clearing pass follows reset.
`timescale 1ns / 1ps
`include "generational_handle_table_top_defines.svh"

module generational_handle_table_top #(
  parameter int SLOTS = ght_pkg::SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [7:0]  handle_index,
  input  logic [31:0] handle_generation,
  input  logic [7:0]  type_code,
  input  logic [31:0] owner_id,
  input  logic [31:0] obj_size,
  input  logic [7:0]  set_mask,
  input  logic [7:0]  clear_mask,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [5:0]  result_index,
  output logic [31:0] result_generation,
  output logic [7:0]  result_type,
  output logic [31:0] result_owner,
  output logic [7:0]  result_flags,
  output logic [31:0] result_size,
  output logic [31:0] result_capacity,
  output logic [6:0]  live_entries
);
  import ght_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ght_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ght_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .mode              (mode),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .type_code         (type_code),
    .owner_id          (owner_id),
    .obj_size          (obj_size),
    .set_mask          (set_mask),
    .clear_mask        (clear_mask),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .status            (status),
    .result_index      (result_index),
    .result_generation (result_generation),
    .result_type       (result_type),
    .result_owner      (result_owner),
    .result_flags      (result_flags),
    .result_size       (result_size),
    .result_capacity   (result_capacity),
    .live_entries      (live_entries)
  );

  `GHT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted beat not held off")
  `GHT_ASSERT_NOW(a_full_index, out_valid && status == ST_FULL, result_index == 6'd0, "full alloc index not zero")
  `GHT_ASSERT_NOW(a_bad_size_zero, out_valid && status == ST_BAD_SIZE, result_generation == 32'd0 && result_flags == 8'd0, "bad size reports entry fields")
  `GHT_ASSERT_NOW(a_ok_alloc_in_use, out_valid && status == ST_OK && result_flags == 8'd0, result_size == 32'd0, "cleared entry reports size")

endmodule
